### hw/rtl/rsacm_pkg.sv
// package for the per-character rsa modular exponentiation block
// request and result struct types, register indexes, opcodes and status codes
// no dependencies
package rsacm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CODE_W = 33;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] CODE_OFFSET = 32'd96;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_LOW_CODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_EXP = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] residue;
    logic [CODE_W-1:0] shifted_code;
    logic              status;
  } out_t;

endpackage

### hw/rtl/textbook_rsa_char_modexp.sv
// top level of the per-character rsa modular exponentiation block
// square-and-multiply over one shared bit-serial modular multiplier
// depends on rsacm_pkg
//
// usage:
//   configuration: cfg_valid/cfg_ready write channel, cfg_index selects modulus (0),
//   encrypt exponent (1) or decrypt exponent (2); cfg_ready is always high.
//   request: in_data is taken at a clock edge with start high and busy low.
//   opcode encrypt subtracts 96 from the code before exponentiation, decrypt uses
//   the value as is; both bases are first reduced modulo the modulus.
//   result: out_data is valid for one cycle while out_strobe is high; the receiver
//   cannot stall, so every result must be taken in its cycle.
//   timing: the shared unit does one interleaved add-and-reduce step per cycle.
//   the base reduction costs one multiply, every exponent bit one squaring, and
//   every set exponent bit one more multiply. an encrypt code below 96 or a zero
//   modulus answers in the cycle after the request. busy is high for the whole job.
//   reset: modulus returns to 1, both exponents to 0, the sequencer to idle.
module textbook_rsa_char_modexp #(
  parameter int unsigned MOD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rsacm_pkg::in_t                   in_data,
  output logic                             out_strobe,
  output rsacm_pkg::out_t                  out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsacm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsacm_pkg::DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned W = MOD_BITS;
  localparam int unsigned DW = rsacm_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BASE = 2'd1;
  localparam logic [1:0] ST_SQR  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;

  logic [W-1:0]       modulus_r;
  logic [DW-1:0]      enc_exp_r;
  logic [DW-1:0]      dec_exp_r;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   ebit_r, ebit_nxt;
  logic [DW-1:0]      exp_r, exp_nxt;
  logic [W-1:0]       base_r, base_nxt;
  logic [W-1:0]       pow_r, pow_nxt;
  logic [W-1:0]       mm_acc_r, mm_acc_nxt;
  logic [W-1:0]       mm_x_r, mm_x_nxt;
  logic [DW-1:0]      mm_y_r, mm_y_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  rsacm_pkg::out_t    out_data_r, out_data_nxt;

  logic [W-1:0]       one_m;
  logic [W+1:0]       mm_t;
  logic [W+2:0]       mm_d1, mm_d2;
  logic [W-1:0]       mm_r;
  logic [DW-1:0]      base_raw;
  logic [DW-1:0]      res_wide;
  logic               last_step;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data = out_data_r;

  // 1 mod m, which is 0 for a modulus of one
  assign one_m = (modulus_r == W'(1)) ? '0 : W'(1);

  // shared unit: acc = 2*acc + (y msb ? x : 0), then reduce below m
  assign mm_t = {1'b0, mm_acc_r, 1'b0} + (mm_y_r[DW-1] ? {2'b00, mm_x_r} : '0);
  assign mm_d1 = {1'b0, mm_t} - {3'b000, modulus_r};
  assign mm_d2 = {1'b0, mm_t} - {2'b00, modulus_r, 1'b0};
  always_comb begin
    if (!mm_d2[W+2]) begin
      mm_r = mm_d2[W-1:0];
    end else if (!mm_d1[W+2]) begin
      mm_r = mm_d1[W-1:0];
    end else begin
      mm_r = mm_t[W-1:0];
    end
  end

  assign last_step = (cnt_r == '0);
  assign base_raw = (in_data.opcode == rsacm_pkg::OP_ENC) ?
                    (in_data.value - rsacm_pkg::CODE_OFFSET) : in_data.value;
  assign res_wide = DW'(mm_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ebit_nxt = ebit_r;
    exp_nxt = exp_r;
    base_nxt = base_r;
    pow_nxt = pow_r;
    mm_acc_nxt = mm_acc_r;
    mm_x_nxt = mm_x_r;
    mm_y_nxt = mm_y_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.opcode == rsacm_pkg::OP_ENC &&
              in_data.value < rsacm_pkg::CODE_OFFSET) begin
            out_strobe_nxt = 1'b1;
            out_data_nxt.residue = '0;
            out_data_nxt.shifted_code = '0;
            out_data_nxt.status = rsacm_pkg::STATUS_LOW_CODE;
          end else if (modulus_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_data_nxt.residue = '0;
            out_data_nxt.shifted_code = {1'b0, rsacm_pkg::CODE_OFFSET};
            out_data_nxt.status = rsacm_pkg::STATUS_OK;
          end else begin
            exp_nxt = (in_data.opcode == rsacm_pkg::OP_ENC) ? enc_exp_r : dec_exp_r;
            mm_acc_nxt = '0;
            mm_x_nxt = one_m;
            mm_y_nxt = base_raw;
            cnt_nxt = '1;
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE, ST_SQR, ST_MUL: begin
        mm_acc_nxt = mm_r;
        mm_y_nxt = {mm_y_r[DW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last_step) begin
          mm_acc_nxt = '0;
          cnt_nxt = '1;
          if (state_r == ST_BASE) begin
            base_nxt = mm_r;
            pow_nxt = one_m;
            ebit_nxt = '1;
            mm_x_nxt = one_m;
            mm_y_nxt = DW'(one_m);
            state_nxt = ST_SQR;
          end else begin
            pow_nxt = mm_r;
            if (state_r == ST_SQR && exp_r[ebit_r]) begin
              mm_x_nxt = base_r;
              mm_y_nxt = res_wide;
              state_nxt = ST_MUL;
            end else if (ebit_r == '0) begin
              out_strobe_nxt = 1'b1;
              out_data_nxt.residue = res_wide;
              out_data_nxt.shifted_code = {1'b0, res_wide} + {1'b0, rsacm_pkg::CODE_OFFSET};
              out_data_nxt.status = rsacm_pkg::STATUS_OK;
              state_nxt = ST_IDLE;
            end else begin
              ebit_nxt = ebit_r - CNT_W'(1);
              mm_x_nxt = mm_r;
              mm_y_nxt = res_wide;
              state_nxt = ST_SQR;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_strobe_r <= 1'b0;
      modulus_r <= W'(1);
      enc_exp_r <= '0;
      dec_exp_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsacm_pkg::REG_MODULUS: modulus_r <= cfg_wdata[W-1:0];
          rsacm_pkg::REG_ENC_EXP: enc_exp_r <= cfg_wdata;
          rsacm_pkg::REG_DEC_EXP: dec_exp_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ebit_r <= ebit_nxt;
    exp_r <= exp_nxt;
    base_r <= base_nxt;
    pow_r <= pow_nxt;
    mm_acc_r <= mm_acc_nxt;
    mm_x_r <= mm_x_nxt;
    mm_y_r <= mm_y_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/rsacm_checker.sv
// port-level checker for the per-character rsa modular exponentiation block
// bound to textbook_rsa_char_modexp; depends on rsacm_pkg
module rsacm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input rsacm_pkg::out_t                 out_data
);

  // an accepted request either starts a job or answers at once
  a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request accepted without job or result");

  // end of a job always comes with its result
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("job ended without result");

  // no result while a job is still running
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result during job");

  a_low_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == rsacm_pkg::STATUS_LOW_CODE) |->
      (out_data.residue == '0 && out_data.shifted_code == '0))
    else $error("flagged result not cleared");

  a_shift_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == rsacm_pkg::STATUS_OK) |->
      (out_data.shifted_code == ({1'b0, out_data.residue} + {1'b0, rsacm_pkg::CODE_OFFSET})))
    else $error("shifted code does not match residue");

endmodule

bind textbook_rsa_char_modexp rsacm_checker u_rsacm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

### verif/testbench.sv
// testbench for textbook_rsa_char_modexp: per-character modular exponentiation
// with a predictor and an in-order check of every result; depends on rsacm_pkg
// and the block's rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT = 20_000_000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned DRAIN_CYCLES = 2100;

  class modexp_ledger;
    logic [rsacm_pkg::DATA_W-1:0] modulus_reg;
    logic [rsacm_pkg::DATA_W-1:0] enc_exp_reg;
    logic [rsacm_pkg::DATA_W-1:0] dec_exp_reg;
    logic [rsacm_pkg::DATA_W-1:0] last_cipher;
    rsacm_pkg::out_t awaited_codes[$];
    int mismatches;
    int requests;
    int results;

    function new();
      modulus_reg = 1;
      enc_exp_reg = '0;
      dec_exp_reg = '0;
      last_cipher = '0;
      mismatches = 0;
      requests = 0;
      results = 0;
    endfunction

    function void set_register(logic [rsacm_pkg::CFG_IDX_W-1:0] idx,
                               logic [rsacm_pkg::DATA_W-1:0] data);
      case (idx)
        rsacm_pkg::REG_MODULUS: modulus_reg = data;
        rsacm_pkg::REG_ENC_EXP: enc_exp_reg = data;
        rsacm_pkg::REG_DEC_EXP: dec_exp_reg = data;
        default: ;
      endcase
    endfunction

    function logic [rsacm_pkg::DATA_W-1:0] mod_power(logic [rsacm_pkg::DATA_W-1:0] base,
                                                     logic [rsacm_pkg::DATA_W-1:0] expo,
                                                     logic [rsacm_pkg::DATA_W-1:0] m);
      logic [63:0] acc;
      logic [63:0] b;
      logic [63:0] m64;
      if (m == '0) return '0;
      m64 = {32'b0, m};
      b = {32'b0, base} % m64;
      acc = 64'd1 % m64;
      for (int k = rsacm_pkg::DATA_W - 1; k >= 0; k--) begin
        acc = (acc * acc) % m64;
        if (expo[k]) acc = (acc * b) % m64;
      end
      return acc[rsacm_pkg::DATA_W-1:0];
    endfunction

    function void note_request(rsacm_pkg::in_t req);
      rsacm_pkg::out_t want;
      logic [rsacm_pkg::DATA_W-1:0] r;
      requests++;
      if (req.opcode == rsacm_pkg::OP_ENC && req.value < rsacm_pkg::CODE_OFFSET) begin
        want.residue = '0;
        want.shifted_code = '0;
        want.status = rsacm_pkg::STATUS_LOW_CODE;
      end else begin
        if (req.opcode == rsacm_pkg::OP_ENC) begin
          r = mod_power(req.value - rsacm_pkg::CODE_OFFSET, enc_exp_reg, modulus_reg);
          last_cipher = r;
        end else begin
          r = mod_power(req.value, dec_exp_reg, modulus_reg);
        end
        want.residue = r;
        want.shifted_code = {1'b0, r} + {1'b0, rsacm_pkg::CODE_OFFSET};
        want.status = rsacm_pkg::STATUS_OK;
      end
      awaited_codes.push_back(want);
    endfunction

    task report(string what, logic [rsacm_pkg::CODE_W-1:0] got,
                logic [rsacm_pkg::CODE_W-1:0] want);
      mismatches++;
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(rsacm_pkg::out_t got);
      rsacm_pkg::out_t want;
      results++;
      if (awaited_codes.size() == 0) begin
        report("unexpected result", {1'b0, got.residue}, '0);
        return;
      end
      want = awaited_codes.pop_front();
      if (got.residue !== want.residue)
        report("residue", {1'b0, got.residue}, {1'b0, want.residue});
      if (got.shifted_code !== want.shifted_code)
        report("shifted_code", got.shifted_code, want.shifted_code);
      if (got.status !== want.status)
        report("status", {32'b0, got.status}, {32'b0, want.status});
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rsacm_pkg::in_t in_data = '0;
  logic out_strobe;
  rsacm_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rsacm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsacm_pkg::DATA_W-1:0] cfg_wdata = '0;

  modexp_ledger ledger;
  int unsigned cycles = 0;
  int key_settings = 0;
  bit steady = 1'b0;

  textbook_rsa_char_modexp dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) ledger.check_result(out_data);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 2500);
  endfunction

  function automatic logic [rsacm_pkg::DATA_W-1:0] pick_modulus();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r == 1) return 32'd1;
    if (r == 2) return 32'd0;
    if (r < 7) return $urandom_range(2, 5000);
    if (r < 10) return {1'b1, 31'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [rsacm_pkg::DATA_W-1:0] pick_exponent();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return 32'd1;
    if (r == 2) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(2, 100);
    return $urandom;
  endfunction

  task automatic load_key(input logic [rsacm_pkg::DATA_W-1:0] m,
                          input logic [rsacm_pkg::DATA_W-1:0] e,
                          input logic [rsacm_pkg::DATA_W-1:0] d);
    logic [rsacm_pkg::CFG_IDX_W-1:0] idx [3];
    logic [rsacm_pkg::DATA_W-1:0] vals [3];
    idx = '{rsacm_pkg::REG_MODULUS, rsacm_pkg::REG_ENC_EXP, rsacm_pkg::REG_DEC_EXP};
    vals = '{m, e, d};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      ledger.set_register(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  task automatic send_item(input logic op, input logic [rsacm_pkg::DATA_W-1:0] v,
                           input bit last);
    rsacm_pkg::in_t req;
    int unsigned g;
    req = '{opcode: op, value: v};
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    ledger.note_request(req);
    g = pick_gap();
    if (g > 0 || last) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (ledger.awaited_codes.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic random_item(input bit last);
    logic op;
    logic [rsacm_pkg::DATA_W-1:0] v;
    int unsigned r;
    op = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 19);
    if (op == rsacm_pkg::OP_ENC) begin
      if (r < 14) v = $urandom_range(96, 255);
      else if (r < 17) v = $urandom_range(0, 95);
      else v = $urandom;
    end else begin
      if (r < 7) v = ledger.last_cipher;
      else if (r < 15 && ledger.modulus_reg != '0) v = $urandom % ledger.modulus_reg;
      else v = $urandom;
    end
    send_item(op, v, last);
  endtask

  initial begin
    logic [rsacm_pkg::DATA_W-1:0] m;
    logic [rsacm_pkg::DATA_W-1:0] e;
    logic [rsacm_pkg::DATA_W-1:0] d;
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: modulus one, zero exponents
    send_item(rsacm_pkg::OP_ENC, 32'd96, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd5, 1'b1);
    drain();

    load_key(32'd3233, 32'd17, 32'd2753);
    send_item(rsacm_pkg::OP_ENC, 32'd0, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd95, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd96, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd97, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd122, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd255, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd256, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'hFFFF_FFFF, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd0, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd1, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd3232, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd3233, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'hFFFF_FFFF, 1'b1);
    drain();

    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(rsacm_pkg::OP_ENC, 32'd255, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'hFFFF_FFFE, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd0, 1'b1);
    drain();

    // zero modulus answers at once
    load_key(32'd0, 32'd5, 32'd7);
    send_item(rsacm_pkg::OP_ENC, 32'd200, 1'b0);
    send_item(rsacm_pkg::OP_DEC, 32'd7, 1'b0);
    send_item(rsacm_pkg::OP_ENC, 32'd10, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        m = 32'd3233;
        e = 32'd17;
        d = 32'd2753;
      end else if (ph == 1) begin
        m = 32'd143;
        e = 32'd7;
        d = 32'd103;
      end else begin
        m = pick_modulus();
        e = pick_exponent();
        d = pick_exponent();
      end
      load_key(m, e, d);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(i == PHASE_ITEMS - 1);
      drain();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d requests and %0d results over %0d key settings",
             ledger.requests, ledger.results, key_settings);
    $display("%0d mismatches, %0d results still awaited",
             ledger.mismatches, ledger.awaited_codes.size());
    if (ledger.mismatches == 0 && ledger.awaited_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
